>>> src/lbb_pkg.sv
// ----------------------------------------------------------------------------
// lbb_pkg
// shared types and constants of the lru block buffer engine
// ----------------------------------------------------------------------------
package lbb_pkg;

	localparam int unsigned FILE_W  = 8;
	localparam int unsigned BLOCK_W = 16;
	localparam int unsigned TAG_W   = FILE_W + BLOCK_W;
	localparam int unsigned PIN_W   = 16;
	localparam int unsigned SLOT_W  = 4;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_READ_FAIL  = 2'd1;
	localparam logic [1:0] STATUS_ALL_PINNED = 2'd2;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_TSCAN_RD = 13'b0000000000010,
		ST_TSCAN_CK = 13'b0000000000100,
		ST_OSCAN_RD = 13'b0000000001000,
		ST_OSCAN_CK = 13'b0000000010000,
		ST_SHIFT_RD = 13'b0000000100000,
		ST_SHIFT_WR = 13'b0000001000000,
		ST_TAIL_WR  = 13'b0000010000000,
		ST_FILL     = 13'b0000100000000,
		ST_PSCAN_RD = 13'b0001000000000,
		ST_PSCAN_CK = 13'b0010000000000,
		ST_VIC_RD   = 13'b0100000000000,
		ST_VIC_CK   = 13'b1000000000000
	} state_t;

endpackage

>>> src/lbb_ram.sv
// ----------------------------------------------------------------------------
// lbb_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lbb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/lru_block_buffer_with_pinning_unit.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_with_pinning_unit
// tag and lru replacement engine for a pool of disk-block slots with pinning
// ----------------------------------------------------------------------------
// A request (start high while busy is low) names a file and block. The engine
// answers with exactly one result, shown for one cycle with done high; the
// receiver cannot stall it. How long a request takes depends on walking the
// tag ram and the recency ram one entry at a time through their single read
// ports. A hit searches the tags up to its slot; when the slot is unpinned,
// it also locates the slot in the recency list, closes the gap and appends
// it. A miss searches all used tags, after which a failed fetch ends at once,
// a fill takes the next free slot, and a miss in a full pool scans the list
// up to and including the first unpinned entry and then reads the victim's
// tag, or ends at the end of the list when every slot is pinned. busy drops
// in the cycle that shows done, so the next request can be taken right then.
// pin_mask may only be written while busy is low. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module lru_block_buffer_with_pinning_unit #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [lbb_pkg::FILE_W-1:0]  file_id,
	input  logic [lbb_pkg::BLOCK_W-1:0] block_number,
	input  logic                        disk_read_ok,
	input  logic                        content_changed,
	input  logic                        pin_mask_we,
	input  logic [lbb_pkg::PIN_W-1:0]   pin_mask_wdata,
	output logic                        done,
	output logic                        hit,
	output logic [lbb_pkg::SLOT_W-1:0]  slot,
	output logic                        evicted,
	output logic [lbb_pkg::FILE_W-1:0]  victim_file,
	output logic [lbb_pkg::BLOCK_W-1:0] victim_block,
	output logic                        write_back,
	output logic [1:0]                  status
);

	// slot index width and fill count width
	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	lbb_pkg::state_t state_q;

	// request latched at accept
	logic                        cmd_q;
	logic [lbb_pkg::FILE_W-1:0]  file_q;
	logic [lbb_pkg::BLOCK_W-1:0] blk_q;
	logic                        ok_q;
	logic                        chg_q;

	// scan position, chosen slot, fill count, head of the circular lru list
	logic [CW-1:0] k_q;
	logic [SW-1:0] s_q;
	logic [CW-1:0] used_q;
	logic [SW-1:0] head_q;

	logic [lbb_pkg::PIN_W-1:0] pin_mask_q;
	logic [SLOTS-1:0]          dirty_q;
	logic [SLOTS-1:0]          pin_vec;

	// result registers
	logic                        done_q;
	logic                        hit_q;
	logic [lbb_pkg::SLOT_W-1:0]  slot_q;
	logic                        evicted_q;
	logic [lbb_pkg::FILE_W-1:0]  vfile_q;
	logic [lbb_pkg::BLOCK_W-1:0] vblk_q;
	logic                        wb_q;
	logic [1:0]                  status_q;

	// ram ports
	logic                       tag_we;
	logic [SW-1:0]              tag_waddr;
	logic [SW-1:0]              tag_raddr;
	logic [lbb_pkg::TAG_W-1:0]  tag_rdata;
	logic                       ord_we;
	logic [SW-1:0]              ord_waddr;
	logic [SW-1:0]              ord_wdata;
	logic [SW-1:0]              ord_raddr;
	logic [SW-1:0]              ord_rdata;

	logic tag_match;
	logic set_dirty;
	logic last_pos;

	// slots from 16 upward have no pin bit
	for (genvar i = 0; i < SLOTS; i++) begin : g_pin
		if (i < lbb_pkg::PIN_W) begin : g_has
			assign pin_vec[i] = pin_mask_q[i];
		end else begin : g_none
			assign pin_vec[i] = 1'b0;
		end
	end

	// logical lru position to physical recency ram address
	function automatic logic [SW-1:0] phys(input logic [CW-1:0] pos, input logic [SW-1:0] hd);
		logic [SW:0] sum;
		sum = {1'b0, hd} + (SW + 1)'(pos);
		if (sum >= (SW + 1)'(SLOTS)) begin
			sum = sum - (SW + 1)'(SLOTS);
		end
		return sum[SW-1:0];
	endfunction

	assign tag_match = (tag_rdata == {file_q, blk_q});
	assign set_dirty = (cmd_q == lbb_pkg::CMD_WRITE) && chg_q;
	assign last_pos  = ((CW + 1)'(k_q) + (CW + 1)'(1)) >= (CW + 1)'(used_q);

	lbb_ram #(
		.WIDTH (lbb_pkg::TAG_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata ({file_q, blk_q}),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	lbb_ram #(
		.WIDTH (SW),
		.DEPTH (SLOTS)
	) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	// ram address and write control per state
	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = s_q;
		tag_raddr = k_q[SW-1:0];
		ord_we    = 1'b0;
		ord_waddr = phys(k_q, head_q);
		ord_wdata = ord_rdata;
		ord_raddr = phys(k_q, head_q);
		case (state_q)
			lbb_pkg::ST_VIC_RD: begin
				tag_raddr = s_q;
			end
			lbb_pkg::ST_VIC_CK: begin
				tag_we = 1'b1;
			end
			lbb_pkg::ST_FILL: begin
				// free slots are taken in index order
				tag_we    = 1'b1;
				tag_waddr = used_q[SW-1:0];
				ord_we    = 1'b1;
				ord_waddr = phys(used_q, head_q);
				ord_wdata = used_q[SW-1:0];
			end
			lbb_pkg::ST_SHIFT_RD: begin
				ord_raddr = phys(k_q + CW'(1), head_q);
			end
			lbb_pkg::ST_SHIFT_WR: begin
				// close the gap: entry k takes entry k+1
				ord_we = 1'b1;
			end
			lbb_pkg::ST_TAIL_WR: begin
				// hit slot becomes most recent
				ord_we    = 1'b1;
				ord_waddr = phys(used_q - CW'(1), head_q);
				ord_wdata = s_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lbb_pkg::ST_IDLE;
			used_q     <= '0;
			head_q     <= '0;
			pin_mask_q <= '0;
			dirty_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (pin_mask_we) begin
				pin_mask_q <= pin_mask_wdata;
			end
			case (state_q)
				lbb_pkg::ST_IDLE: begin
					if (start) begin
						k_q     <= '0;
						state_q <= lbb_pkg::ST_TSCAN_RD;
					end
				end
				lbb_pkg::ST_TSCAN_RD: begin
					if (k_q == used_q) begin
						// miss
						if (!ok_q) begin
							done_q    <= 1'b1;
							hit_q     <= 1'b0;
							slot_q    <= '0;
							evicted_q <= 1'b0;
							vfile_q   <= '0;
							vblk_q    <= '0;
							wb_q      <= 1'b0;
							status_q  <= lbb_pkg::STATUS_READ_FAIL;
							state_q   <= lbb_pkg::ST_IDLE;
						end else if (used_q < CW'(SLOTS)) begin
							state_q <= lbb_pkg::ST_FILL;
						end else begin
							k_q     <= '0;
							state_q <= lbb_pkg::ST_PSCAN_RD;
						end
					end else begin
						state_q <= lbb_pkg::ST_TSCAN_CK;
					end
				end
				lbb_pkg::ST_TSCAN_CK: begin
					if (tag_match) begin
						s_q <= k_q[SW-1:0];
						if (set_dirty) begin
							dirty_q[k_q[SW-1:0]] <= 1'b1;
						end
						if (pin_vec[k_q[SW-1:0]]) begin
							// pinned hit leaves the lru order alone
							done_q    <= 1'b1;
							hit_q     <= 1'b1;
							slot_q    <= lbb_pkg::SLOT_W'(k_q[SW-1:0]);
							evicted_q <= 1'b0;
							vfile_q   <= '0;
							vblk_q    <= '0;
							wb_q      <= 1'b0;
							status_q  <= lbb_pkg::STATUS_OK;
							state_q   <= lbb_pkg::ST_IDLE;
						end else begin
							k_q     <= '0;
							state_q <= lbb_pkg::ST_OSCAN_RD;
						end
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= lbb_pkg::ST_TSCAN_RD;
					end
				end
				lbb_pkg::ST_OSCAN_RD: begin
					state_q <= lbb_pkg::ST_OSCAN_CK;
				end
				lbb_pkg::ST_OSCAN_CK: begin
					if (ord_rdata == s_q) begin
						state_q <= lbb_pkg::ST_SHIFT_RD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= lbb_pkg::ST_OSCAN_RD;
					end
				end
				lbb_pkg::ST_SHIFT_RD: begin
					if (last_pos) begin
						state_q <= lbb_pkg::ST_TAIL_WR;
					end else begin
						state_q <= lbb_pkg::ST_SHIFT_WR;
					end
				end
				lbb_pkg::ST_SHIFT_WR: begin
					k_q     <= k_q + CW'(1);
					state_q <= lbb_pkg::ST_SHIFT_RD;
				end
				lbb_pkg::ST_TAIL_WR: begin
					done_q    <= 1'b1;
					hit_q     <= 1'b1;
					slot_q    <= lbb_pkg::SLOT_W'(s_q);
					evicted_q <= 1'b0;
					vfile_q   <= '0;
					vblk_q    <= '0;
					wb_q      <= 1'b0;
					status_q  <= lbb_pkg::STATUS_OK;
					state_q   <= lbb_pkg::ST_IDLE;
				end
				lbb_pkg::ST_FILL: begin
					used_q                <= used_q + CW'(1);
					dirty_q[used_q[SW-1:0]] <= set_dirty;
					done_q    <= 1'b1;
					hit_q     <= 1'b0;
					slot_q    <= lbb_pkg::SLOT_W'(used_q[SW-1:0]);
					evicted_q <= 1'b0;
					vfile_q   <= '0;
					vblk_q    <= '0;
					wb_q      <= 1'b0;
					status_q  <= lbb_pkg::STATUS_OK;
					state_q   <= lbb_pkg::ST_IDLE;
				end
				lbb_pkg::ST_PSCAN_RD: begin
					if (k_q == used_q) begin
						// every slot pinned, full rotation leaves order as it was
						done_q    <= 1'b1;
						hit_q     <= 1'b0;
						slot_q    <= '0;
						evicted_q <= 1'b0;
						vfile_q   <= '0;
						vblk_q    <= '0;
						wb_q      <= 1'b0;
						status_q  <= lbb_pkg::STATUS_ALL_PINNED;
						state_q   <= lbb_pkg::ST_IDLE;
					end else begin
						state_q <= lbb_pkg::ST_PSCAN_CK;
					end
				end
				lbb_pkg::ST_PSCAN_CK: begin
					if (!pin_vec[ord_rdata]) begin
						// rotating past pinned entries and the victim is a head move
						s_q     <= ord_rdata;
						head_q  <= phys(k_q + CW'(1), head_q);
						state_q <= lbb_pkg::ST_VIC_RD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= lbb_pkg::ST_PSCAN_RD;
					end
				end
				lbb_pkg::ST_VIC_RD: begin
					state_q <= lbb_pkg::ST_VIC_CK;
				end
				lbb_pkg::ST_VIC_CK: begin
					dirty_q[s_q] <= set_dirty;
					done_q    <= 1'b1;
					hit_q     <= 1'b0;
					slot_q    <= lbb_pkg::SLOT_W'(s_q);
					evicted_q <= 1'b1;
					vfile_q   <= tag_rdata[lbb_pkg::TAG_W-1:lbb_pkg::BLOCK_W];
					vblk_q    <= tag_rdata[lbb_pkg::BLOCK_W-1:0];
					wb_q      <= dirty_q[s_q];
					status_q  <= lbb_pkg::STATUS_OK;
					state_q   <= lbb_pkg::ST_IDLE;
				end
				default: begin
					state_q <= lbb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (state_q == lbb_pkg::ST_IDLE && start) begin
			cmd_q  <= cmd;
			file_q <= file_id;
			blk_q  <= block_number;
			ok_q   <= disk_read_ok;
			chg_q  <= content_changed;
		end
	end

	assign busy         = (state_q != lbb_pkg::ST_IDLE);
	assign done         = done_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign evicted      = evicted_q;
	assign victim_file  = vfile_q;
	assign victim_block = vblk_q;
	assign write_back   = wb_q;
	assign status       = status_q;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lru block buffer engine with slot pinning
// ----------------------------------------------------------------------------
// Requests go in through the start/busy handshake. An in-bench model of the
// tag store, the recency list and the pin register predicts one result per
// request. Every result strobed on done is checked field by field against
// the oldest prediction. The pin mask is rewritten between phases once the
// engine has drained. Each phase draws its tags from a small random pool, so
// hits, fills, evictions, dirty write-backs and all-pinned misses all occur.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSLOT     = 16;
	localparam int unsigned STALL_MAX = 4000;

	typedef struct packed {
		logic                        hit;
		logic [lbb_pkg::SLOT_W-1:0]  slot;
		logic                        evicted;
		logic [lbb_pkg::FILE_W-1:0]  victim_file;
		logic [lbb_pkg::BLOCK_W-1:0] victim_block;
		logic                        write_back;
		logic [1:0]                  status;
	} lookup_t;

	// model of the pool plus the queue of predicted lookups
	class pool_scoreboard;
		logic [lbb_pkg::FILE_W-1:0]  tag_file  [NSLOT];
		logic [lbb_pkg::BLOCK_W-1:0] tag_block [NSLOT];
		bit                          tag_valid [NSLOT];
		bit                          tag_dirty [NSLOT];
		int unsigned                 lru_order [NSLOT];
		int unsigned                 fill_count;
		logic [lbb_pkg::PIN_W-1:0]   pins;
		lookup_t                     pending[$];
		int unsigned                 errors, checked, n_hit, n_evict, n_wb, n_fail, n_pinned;

		function new();
			for (int s = 0; s < NSLOT; s++) begin
				tag_valid[s] = 0;
				tag_dirty[s] = 0;
				lru_order[s] = 0;
			end
			fill_count = 0;
			pins = '0;
		endfunction

		function bit is_pinned(int unsigned s);
			return s < lbb_pkg::PIN_W && pins[s];
		endfunction

		// take the entry at pos out of the list and append it as most recent
		function void rotate_to_back(int unsigned pos);
			int unsigned v;
			if (pos >= fill_count) return;
			v = lru_order[pos];
			for (int unsigned k = pos; k + 1 < fill_count; k++)
				lru_order[k] = lru_order[k + 1];
			lru_order[fill_count - 1] = v;
		endfunction

		// predict the lookup for an accepted request and update the pool
		function void note_request(logic c, logic [lbb_pkg::FILE_W-1:0] f,
				logic [lbb_pkg::BLOCK_W-1:0] b, logic ok, logic chg);
			lookup_t r;
			int idx;
			int unsigned s;
			r = '0;
			idx = -1;
			for (int i = 0; i < NSLOT; i++)
				if (idx < 0 && tag_valid[i] && tag_file[i] == f && tag_block[i] == b)
					idx = i;
			if (idx >= 0) begin
				if (!is_pinned(idx)) begin
					for (int unsigned k = 0; k < fill_count; k++)
						if (lru_order[k] == idx) begin
							rotate_to_back(k);
							break;
						end
				end
				if (c == lbb_pkg::CMD_WRITE && chg) tag_dirty[idx] = 1;
				r.hit = 1;
				r.slot = idx[lbb_pkg::SLOT_W-1:0];
				n_hit++;
			end else if (!ok) begin
				r.status = lbb_pkg::STATUS_READ_FAIL;
				n_fail++;
			end else begin
				if (fill_count < NSLOT) begin
					s = fill_count;
					lru_order[fill_count] = s;
					fill_count++;
				end else begin
					for (int unsigned k = 0; k < fill_count && is_pinned(lru_order[0]); k++)
						rotate_to_back(0);
					if (is_pinned(lru_order[0])) begin
						r.status = lbb_pkg::STATUS_ALL_PINNED;
						n_pinned++;
						pending.insert(pending.size(), r);
						return;
					end
					s = lru_order[0];
					r.evicted = 1;
					r.victim_file = tag_file[s];
					r.victim_block = tag_block[s];
					r.write_back = tag_dirty[s];
					n_evict++;
					if (tag_dirty[s]) n_wb++;
					rotate_to_back(0);
				end
				tag_file[s] = f;
				tag_block[s] = b;
				tag_valid[s] = 1;
				tag_dirty[s] = (c == lbb_pkg::CMD_WRITE && chg);
				r.slot = s[lbb_pkg::SLOT_W-1:0];
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(lookup_t got);
			lookup_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = pending[0];
			pending.delete(0);
			checked++;
			if (got.hit != exp.hit)
				$display("%0t: hit exp %0d got %0d", $time, exp.hit, got.hit);
			if (got.slot != exp.slot)
				$display("%0t: slot exp %0d got %0d", $time, exp.slot, got.slot);
			if (got.evicted != exp.evicted)
				$display("%0t: evicted exp %0d got %0d", $time, exp.evicted, got.evicted);
			if (got.victim_file != exp.victim_file)
				$display("%0t: victim_file exp %0h got %0h", $time,
					exp.victim_file, got.victim_file);
			if (got.victim_block != exp.victim_block)
				$display("%0t: victim_block exp %0h got %0h", $time,
					exp.victim_block, got.victim_block);
			if (got.write_back != exp.write_back)
				$display("%0t: write_back exp %0d got %0d", $time,
					exp.write_back, got.write_back);
			if (got.status != exp.status)
				$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
			if (got != exp) errors++;
		endfunction
	endclass

	logic                        clk = 0;
	logic                        arst_n = 0;
	logic                        start = 0;
	logic                        busy;
	logic                        cmd = lbb_pkg::CMD_READ;
	logic [lbb_pkg::FILE_W-1:0]  file_id = '0;
	logic [lbb_pkg::BLOCK_W-1:0] block_number = '0;
	logic                        disk_read_ok = 0;
	logic                        content_changed = 0;
	logic                        pin_mask_we = 0;
	logic [lbb_pkg::PIN_W-1:0]   pin_mask_wdata = '0;
	logic                        done;
	lookup_t                     res;

	pool_scoreboard sb = new();

	// tag pool of the current phase, requests sent, watchdog
	logic [lbb_pkg::FILE_W-1:0]  pool_file  [24];
	logic [lbb_pkg::BLOCK_W-1:0] pool_block [24];
	int unsigned                 sent = 0;
	int unsigned                 quiet_cycles = 0;

	always #5 clk = ~clk;

	lru_block_buffer_with_pinning_unit #(.SLOTS(NSLOT)) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.file_id         (file_id),
		.block_number    (block_number),
		.disk_read_ok    (disk_read_ok),
		.content_changed (content_changed),
		.pin_mask_we     (pin_mask_we),
		.pin_mask_wdata  (pin_mask_wdata),
		.done            (done),
		.hit             (res.hit),
		.slot            (res.slot),
		.evicted         (res.evicted),
		.victim_file     (res.victim_file),
		.victim_block    (res.victim_block),
		.write_back      (res.write_back),
		.status          (res.status)
	);

	// results cannot be held off, so every done strobe is checked right away
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(res);
	end

	// watchdog: too long without any request or result means a hang
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_MAX) begin
				$display("%0t: watchdog expired, %0d lookups outstanding", $time,
					sb.pending.size());
				$display("** lru_block_buffer_with_pinning_unit: FAILED **");
				$finish;
			end
		end
	end

	// send one request; the call returns at the edge after acceptance
	task automatic send_request(logic c, logic [lbb_pkg::FILE_W-1:0] f,
			logic [lbb_pkg::BLOCK_W-1:0] b, logic ok, logic chg);
		// random gaps except in a long burst in the middle of the run
		if (!(sent >= 120 && sent < 220))
			while ($urandom_range(99) < 31) @(posedge clk);
		start <= 1;
		cmd <= c;
		file_id <= f;
		block_number <= b;
		disk_read_ok <= ok;
		content_changed <= chg;
		do @(posedge clk); while (busy);
		sb.note_request(c, f, b, ok, chg);
		sent++;
		start <= 0;
		@(posedge clk);
	endtask

	// let every pending lookup come back, then write the pin register
	task automatic drain();
		while (sb.pending.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_pins(logic [lbb_pkg::PIN_W-1:0] v);
		drain();
		pin_mask_we <= 1;
		pin_mask_wdata <= v;
		@(posedge clk);
		sb.pins = v;
		pin_mask_we <= 0;
		@(posedge clk);
	endtask

	// fresh tag pool: random bits everywhere, extremes in the first entries
	task automatic new_pool();
		for (int i = 0; i < 24; i++) begin
			pool_file[i] = lbb_pkg::FILE_W'($urandom_range(255));
			pool_block[i] = lbb_pkg::BLOCK_W'($urandom_range(65535));
		end
		pool_file[0] = '0;
		pool_block[0] = '0;
		pool_file[1] = '1;
		pool_block[1] = '1;
	endtask

	task automatic random_phase(int unsigned n, int unsigned span);
		int unsigned j;
		for (int unsigned i = 0; i < n; i++) begin
			j = $urandom_range(span - 1);
			if ($urandom_range(9) == 0)
				send_request(1'($urandom_range(1)), lbb_pkg::FILE_W'($urandom_range(255)),
					lbb_pkg::BLOCK_W'($urandom_range(65535)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else
				send_request(1'($urandom_range(1)), pool_file[j], pool_block[j],
					$urandom_range(7) != 0, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: failed fetch on an empty pool, then fill all slots
		new_pool();
		write_pins('0);
		send_request(lbb_pkg::CMD_READ, 8'hff, 16'hffff, 1'b0, 1'b1);
		for (int i = 0; i < NSLOT; i++)
			send_request(i[0] ? lbb_pkg::CMD_WRITE : lbb_pkg::CMD_READ, pool_file[i],
				pool_block[i], 1'b1, i[1]);
		// read hit, write hit with and without a content change
		send_request(lbb_pkg::CMD_READ, pool_file[0], pool_block[0], 1'b0, 1'b1);
		send_request(lbb_pkg::CMD_WRITE, pool_file[1], pool_block[1], 1'b1, 1'b0);
		send_request(lbb_pkg::CMD_WRITE, pool_file[2], pool_block[2], 1'b0, 1'b1);
		// misses in a full pool: clean and dirty victims, failed fetch
		send_request(lbb_pkg::CMD_WRITE, pool_file[16], pool_block[16], 1'b1, 1'b1);
		send_request(lbb_pkg::CMD_READ, pool_file[17], pool_block[17], 1'b1, 1'b0);
		send_request(lbb_pkg::CMD_READ, pool_file[18], pool_block[18], 1'b0, 1'b0);

		// every slot pinned: misses report all pinned, hits still work
		write_pins('1);
		send_request(lbb_pkg::CMD_READ, pool_file[19], pool_block[19], 1'b1, 1'b0);
		send_request(lbb_pkg::CMD_WRITE, pool_file[16], pool_block[16], 1'b1, 1'b1);
		send_request(lbb_pkg::CMD_WRITE, pool_file[20], pool_block[20], 1'b1, 1'b1);
		// pinned entries at the front get rotated past
		write_pins(16'h7fff);
		send_request(lbb_pkg::CMD_READ, pool_file[21], pool_block[21], 1'b1, 1'b0);
		send_request(lbb_pkg::CMD_READ, pool_file[22], pool_block[22], 1'b1, 1'b0);

		// random phases under several pin settings, extremes included
		random_phase(90, 24);
		write_pins('0);
		new_pool();
		random_phase(110, 20);
		write_pins(16'h8001);
		random_phase(70, 24);
		write_pins(lbb_pkg::PIN_W'($urandom_range(65535)));
		new_pool();
		random_phase(70, 22);
		write_pins(16'hffff);
		random_phase(30, 24);
		write_pins(16'h00ff);
		random_phase(60, 24);

		drain();
		repeat (120) @(posedge clk);
		$display("%0d requests, %0d results checked: %0d hits, %0d evictions",
			sent, sb.checked, sb.n_hit, sb.n_evict);
		$display("%0d write-backs, %0d failed fetches, %0d all-pinned misses",
			sb.n_wb, sb.n_fail, sb.n_pinned);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** lru_block_buffer_with_pinning_unit: PASSED **");
		else
			$display("** lru_block_buffer_with_pinning_unit: FAILED **");
		$finish;
	end

endmodule

>>> files.f
src/lbb_pkg.sv
src/lbb_ram.sv
src/lru_block_buffer_with_pinning_unit.sv
verif/tb.sv
